### rtl/core/ale_pkg.sv
// Array list engine: shared field widths, operation codes, status codes and
// parameter defaults. No dependencies.
`timescale 1ns / 1ps

package ale_pkg;

    localparam int unsigned CAPACITY_DEF   = 16;
    localparam int unsigned DATA_WIDTH_DEF = 32;

    localparam int unsigned FUNC_W   = 4;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned INDEX_W  = 4;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned COUNT_W  = 5;

    localparam logic [FUNC_W-1:0] FN_APPEND     = 4'd0;
    localparam logic [FUNC_W-1:0] FN_PREPEND    = 4'd1;
    localparam logic [FUNC_W-1:0] FN_SORTED     = 4'd2;
    localparam logic [FUNC_W-1:0] FN_DROP_LAST  = 4'd3;
    localparam logic [FUNC_W-1:0] FN_DROP_FIRST = 4'd4;
    localparam logic [FUNC_W-1:0] FN_DROP_INDEX = 4'd5;
    localparam logic [FUNC_W-1:0] FN_DROP_VALUE = 4'd6;
    localparam logic [FUNC_W-1:0] FN_READ       = 4'd7;
    localparam logic [FUNC_W-1:0] FN_FIND       = 4'd8;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

endpackage

### rtl/core/ale_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module ale_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/array_list_engine_core.sv
// Array list engine top level: request decode, scan/shift sequencer and result register.
// Depends on ale_pkg and ale_ram.
//
//  channel  handshake           payload
//  request  i_valid / o_ready   i_func, i_value, i_index
//  result   o_valid / i_ready   o_status, o_read_word, o_found_position,
//                               o_count, o_is_full, o_is_empty
//
// One request at a time; every request ends in the result register.
// Status-only, append, drop last: decode, then result. Read: decode, RAM read, result.
// Find / drop value: scan from entry 0. Drops by value, first or index shift the later
// entries down. Prepend / sorted insert: scan (sorted only), shift up from the last
// entry to the gap, then insert; a word after the last entry is written directly.
// One entry moves per cycle. Reset clears state, count and result valid, not storage.
// A held result stalls a request only in its final state, S_FIN.
`timescale 1ns / 1ps

module array_list_engine_core #(
    parameter int unsigned CAPACITY   = ale_pkg::CAPACITY_DEF,
    parameter int unsigned DATA_WIDTH = ale_pkg::DATA_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [ale_pkg::FUNC_W-1:0]         i_func,
    input  logic signed [ale_pkg::VALUE_W-1:0] i_value,
    input  logic [ale_pkg::INDEX_W-1:0]        i_index,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [ale_pkg::STATUS_W-1:0]       o_status,
    output logic signed [ale_pkg::VALUE_W-1:0] o_read_word,
    output logic [ale_pkg::POS_W-1:0]          o_found_position,
    output logic [ale_pkg::COUNT_W-1:0]        o_count,
    output logic                               o_is_full,
    output logic                               o_is_empty
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned DW = DATA_WIDTH;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SCAN = 7'b0000010,
        S_SHUP = 7'b0000100,
        S_SHDN = 7'b0001000,
        S_INS  = 7'b0010000,
        S_READ = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_pos, n_pos;
    logic [ale_pkg::FUNC_W-1:0] r_func, n_func;
    logic [DW-1:0] r_w, n_w;
    logic [ale_pkg::STATUS_W-1:0] r_status, n_status;
    logic [ale_pkg::VALUE_W-1:0] r_rd, n_rd;
    logic [ale_pkg::POS_W-1:0] r_fpos, n_fpos;
    logic r_ovalid, n_ovalid;
    logic [ale_pkg::STATUS_W-1:0] r_o_status, n_o_status;
    logic [ale_pkg::VALUE_W-1:0] r_o_rd, n_o_rd;
    logic [ale_pkg::POS_W-1:0] r_o_pos, n_o_pos;
    logic [ale_pkg::COUNT_W-1:0] r_o_cnt, n_o_cnt;
    logic r_o_full, n_o_full;
    logic r_o_empty, n_o_empty;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;

    logic [DW-1:0] w_in;
    logic [CW-1:0] ptr_p1, ptr_p2, ptr_m1, ptr_m2, cnt_m1, cnt_p1;
    logic          cnt_full, cnt_zero;

    assign w_in     = DW'(i_value);
    assign ptr_p1   = r_ptr + CW'(1);
    assign ptr_p2   = r_ptr + CW'(2);
    assign ptr_m1   = r_ptr - CW'(1);
    assign ptr_m2   = r_ptr - CW'(2);
    assign cnt_m1   = r_cnt - CW'(1);
    assign cnt_p1   = r_cnt + CW'(1);
    assign cnt_full = (r_cnt == CW'(CAPACITY));
    assign cnt_zero = (r_cnt == '0);

    ale_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        logic          do_open;
        logic          do_close;
        logic [CW-1:0] op_p;
        logic [CW-1:0] cl_p;
        logic [CW-1:0] cl_p1;
        logic [DW-1:0] ins_w;
        logic          hit;

        n_state    = r_state;
        n_cnt      = r_cnt;
        n_ptr      = r_ptr;
        n_pos      = r_pos;
        n_func     = r_func;
        n_w        = r_w;
        n_status   = r_status;
        n_rd       = r_rd;
        n_fpos     = r_fpos;
        n_ovalid   = r_ovalid & ~i_ready;
        n_o_status = r_o_status;
        n_o_rd     = r_o_rd;
        n_o_pos    = r_o_pos;
        n_o_cnt    = r_o_cnt;
        n_o_full   = r_o_full;
        n_o_empty  = r_o_empty;
        mem_we     = 1'b0;
        mem_waddr  = r_ptr[AW-1:0];
        mem_wdata  = mem_rdata;
        mem_raddr  = ptr_p1[AW-1:0];
        do_open    = 1'b0;
        do_close   = 1'b0;
        op_p       = '0;
        cl_p       = '0;
        ins_w      = r_w;
        hit        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_func   = i_func;
                    n_w      = w_in;
                    ins_w    = w_in;
                    n_status = ale_pkg::ST_OK;
                    n_rd     = '0;
                    n_fpos   = '0;
                    n_state  = S_FIN;
                    unique case (i_func) inside
                        ale_pkg::FN_APPEND: begin
                            if (cnt_full) begin
                                n_status = ale_pkg::ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_cnt[AW-1:0];
                                mem_wdata = w_in;
                                n_cnt     = cnt_p1;
                            end
                        end
                        ale_pkg::FN_PREPEND: begin
                            if (cnt_full) begin
                                n_status = ale_pkg::ST_FULL;
                            end else begin
                                do_open = 1'b1;
                            end
                        end
                        ale_pkg::FN_SORTED: begin
                            if (cnt_full) begin
                                n_status = ale_pkg::ST_FULL;
                            end else begin
                                n_ptr     = '0;
                                mem_raddr = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        ale_pkg::FN_DROP_LAST: begin
                            if (cnt_zero) begin
                                n_status = ale_pkg::ST_EMPTY;
                            end else begin
                                n_cnt = cnt_m1;
                            end
                        end
                        ale_pkg::FN_DROP_FIRST: begin
                            if (cnt_zero) begin
                                n_status = ale_pkg::ST_EMPTY;
                            end else begin
                                do_close = 1'b1;
                            end
                        end
                        ale_pkg::FN_DROP_INDEX, ale_pkg::FN_READ: begin
                            if (cnt_zero) begin
                                n_status = ale_pkg::ST_EMPTY;
                            end else if (i_index >= r_cnt) begin
                                n_status = ale_pkg::ST_RANGE;
                            end else if (i_func == ale_pkg::FN_DROP_INDEX) begin
                                do_close = 1'b1;
                                cl_p     = CW'(i_index);
                            end else begin
                                mem_raddr = AW'(i_index);
                                n_state   = S_READ;
                            end
                        end
                        ale_pkg::FN_DROP_VALUE, ale_pkg::FN_FIND: begin
                            if (cnt_zero) begin
                                n_status = ale_pkg::ST_EMPTY;
                            end else begin
                                n_ptr     = '0;
                                mem_raddr = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_func == ale_pkg::FN_SORTED) begin
                    hit = !($signed(mem_rdata) < $signed(r_w));
                end else begin
                    hit = (mem_rdata == r_w);
                end
                if (r_ptr >= r_cnt) begin
                    if (r_func == ale_pkg::FN_SORTED) begin
                        do_open = 1'b1;
                        op_p    = r_cnt;
                    end else begin
                        n_status = ale_pkg::ST_NOTFOUND;
                        n_state  = S_FIN;
                    end
                end else if (hit) begin
                    if (r_func == ale_pkg::FN_SORTED) begin
                        do_open = 1'b1;
                        op_p    = r_ptr;
                    end else if (r_func == ale_pkg::FN_DROP_VALUE) begin
                        do_close = 1'b1;
                        cl_p     = r_ptr;
                    end else begin
                        n_fpos  = ale_pkg::POS_W'(r_ptr);
                        n_state = S_FIN;
                    end
                end else begin
                    n_ptr = ptr_p1;
                end
            end
            S_SHDN: begin
                mem_we = 1'b1;
                if (ptr_p2 >= r_cnt) begin
                    n_cnt   = cnt_m1;
                    n_state = S_FIN;
                end else begin
                    n_ptr     = ptr_p1;
                    mem_raddr = ptr_p2[AW-1:0];
                end
            end
            S_SHUP: begin
                mem_we = 1'b1;
                if (ptr_m1 == r_pos) begin
                    n_state = S_INS;
                end else begin
                    n_ptr     = ptr_m1;
                    mem_raddr = ptr_m2[AW-1:0];
                end
            end
            S_INS: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos[AW-1:0];
                mem_wdata = r_w;
                n_cnt     = cnt_p1;
                n_state   = S_FIN;
            end
            S_READ: begin
                n_rd    = ale_pkg::VALUE_W'($signed(mem_rdata));
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_rd     = r_rd;
                    n_o_pos    = r_fpos;
                    n_o_cnt    = ale_pkg::COUNT_W'(r_cnt);
                    n_o_full   = cnt_full;
                    n_o_empty  = cnt_zero;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // open a gap at op_p (shift up) and place the new word there
        if (do_open) begin
            if (op_p == r_cnt) begin
                mem_we    = 1'b1;
                mem_waddr = op_p[AW-1:0];
                mem_wdata = ins_w;
                n_cnt     = cnt_p1;
                n_state   = S_FIN;
            end else begin
                n_ptr     = r_cnt;
                n_pos     = op_p;
                mem_raddr = cnt_m1[AW-1:0];
                n_state   = S_SHUP;
            end
        end

        // close the gap at cl_p (shift down)
        cl_p1 = cl_p + CW'(1);
        if (do_close) begin
            if (cl_p1 >= r_cnt) begin
                n_cnt   = cnt_m1;
                n_state = S_FIN;
            end else begin
                n_ptr     = cl_p;
                mem_raddr = cl_p1[AW-1:0];
                n_state   = S_SHDN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_pos      <= n_pos;
        r_func     <= n_func;
        r_w        <= n_w;
        r_status   <= n_status;
        r_rd       <= n_rd;
        r_fpos     <= n_fpos;
        r_o_status <= n_o_status;
        r_o_rd     <= n_o_rd;
        r_o_pos    <= n_o_pos;
        r_o_cnt    <= n_o_cnt;
        r_o_full   <= n_o_full;
        r_o_empty  <= n_o_empty;
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_status         = r_o_status;
    assign o_read_word      = r_o_rd;
    assign o_found_position = r_o_pos;
    assign o_count          = r_o_cnt;
    assign o_is_full        = r_o_full;
    assign o_is_empty       = r_o_empty;

endmodule

### sim/array_list_checker.sv
// Array list engine checker: keeps its own copy of the list, predicts each result word
// from the accepted request words, and compares results in order. Depends on ale_pkg.
`timescale 1ns / 1ps

module array_list_checker
    import ale_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    input  logic                       i_req_ready,
    input  logic [FUNC_W-1:0]          i_func,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic [INDEX_W-1:0]         i_index,
    input  logic                       i_res_valid,
    input  logic                       i_res_ready,
    input  logic [STATUS_W-1:0]        i_status,
    input  logic signed [VALUE_W-1:0]  i_read_word,
    input  logic [POS_W-1:0]           i_found_position,
    input  logic [COUNT_W-1:0]         i_count,
    input  logic                       i_is_full,
    input  logic                       i_is_empty,
    output int                         o_failures,
    output int                         o_pending
);

    localparam int unsigned LIST_DEPTH = CAPACITY_DEF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  read_word;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  count;
        logic                full;
        logic                empty;
    } list_result_t;

    logic signed [VALUE_W-1:0] list_words [LIST_DEPTH];
    int unsigned               list_len;
    list_result_t              expected_q [$];
    int                        results_seen;

    initial begin
        o_failures   = 0;
        o_pending    = 0;
        list_len     = 0;
        results_seen = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch at result %0d: %s", $realtime, results_seen, msg);
        o_failures++;
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] got,
                               input logic [VALUE_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic remove_at(input int unsigned pos);
        for (int unsigned j = pos; j + 1 < list_len; j++) begin
            list_words[j] = list_words[j + 1];
        end
        list_len--;
    endtask

    task automatic apply_request(input logic [FUNC_W-1:0] f, input logic signed [VALUE_W-1:0] v,
                                 input logic [INDEX_W-1:0] x, output list_result_t r);
        int unsigned p;
        r = '0;
        r.status = ST_OK;
        if (f <= FN_SORTED) begin
            if (list_len >= LIST_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                p = list_len;
                if (f != FN_APPEND) begin
                    p = 0;
                end
                if (f == FN_SORTED) begin
                    while (p < list_len && list_words[p] < v) p++;
                end
                for (int unsigned j = list_len; j > p; j--) begin
                    list_words[j] = list_words[j - 1];
                end
                list_words[p] = v;
                list_len++;
            end
        end else if (f <= FN_FIND) begin
            if (list_len == 0) begin
                r.status = ST_EMPTY;
            end else begin
                case (f)
                    FN_DROP_LAST: begin
                        list_len--;
                    end
                    FN_DROP_FIRST: begin
                        remove_at(0);
                    end
                    FN_DROP_INDEX, FN_READ: begin
                        if (x >= list_len) begin
                            r.status = ST_RANGE;
                        end else if (f == FN_DROP_INDEX) begin
                            remove_at(32'(x));
                        end else begin
                            r.read_word = list_words[x];
                        end
                    end
                    default: begin
                        p = 0;
                        while (p < list_len && list_words[p] != v) p++;
                        if (p >= list_len) begin
                            r.status = ST_NOTFOUND;
                        end else if (f == FN_DROP_VALUE) begin
                            remove_at(p);
                        end else begin
                            r.position = POS_W'(p);
                        end
                    end
                endcase
            end
        end
        r.count = COUNT_W'(list_len);
        r.full  = (list_len == LIST_DEPTH);
        r.empty = (list_len == 0);
    endtask

    always @(posedge i_clk) begin
        list_result_t want;
        if (!i_rst_n) begin
            list_len = 0;
            expected_q.delete();
        end else begin
            if (i_req_valid && i_req_ready) begin
                apply_request(i_func, i_value, i_index, want);
                expected_q.push_back(want);
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result word with no request outstanding");
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", VALUE_W'(i_status), VALUE_W'(want.status));
                    check_field("read_word", i_read_word, want.read_word);
                    check_field("found_position", VALUE_W'(i_found_position),
                                VALUE_W'(want.position));
                    check_field("count", VALUE_W'(i_count), VALUE_W'(want.count));
                    check_field("is_full", VALUE_W'(i_is_full), VALUE_W'(want.full));
                    check_field("is_empty", VALUE_W'(i_is_empty), VALUE_W'(want.empty));
                end
                results_seen++;
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

### sim/array_list_engine_core_test.sv
// Array list engine testbench top: clock, reset, request stimulus with bursty sender and
// stalling receiver, verdict. Depends on ale_pkg, array_list_engine_core, array_list_checker.
`timescale 1ns / 1ps

module array_list_engine_core_test;

    import ale_pkg::*;

    localparam logic [FUNC_W-1:0] FN_FIRST_UNUSED = FN_FIND + 4'd1;
    localparam logic [FUNC_W-1:0] FN_LAST_UNUSED  = 4'd15;
    localparam int RANDOM_WORDS = 650;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 64;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_PROBE} traffic_mode_t;

    logic                       i_clk   = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic [FUNC_W-1:0]          i_func  = FN_APPEND;
    logic signed [VALUE_W-1:0]  i_value = '0;
    logic [INDEX_W-1:0]         i_index = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [STATUS_W-1:0]        o_status;
    logic signed [VALUE_W-1:0]  o_read_word;
    logic [POS_W-1:0]           o_found_position;
    logic [COUNT_W-1:0]         o_count;
    logic                       o_is_full;
    logic                       o_is_empty;

    int            failures;
    int            pending;
    int            cycle_count = 0;
    int            burst_left  = 0;
    bit            long_hold_req = 1'b0;
    traffic_mode_t mode;

    array_list_engine_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_value          (i_value),
        .i_index          (i_index),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_read_word      (o_read_word),
        .o_found_position (o_found_position),
        .o_count          (o_count),
        .o_is_full        (o_is_full),
        .o_is_empty       (o_is_empty)
    );

    array_list_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_ready      (o_ready),
        .i_func           (i_func),
        .i_value          (i_value),
        .i_index          (i_index),
        .i_res_valid      (o_valid),
        .i_res_ready      (i_ready),
        .i_status         (o_status),
        .i_read_word      (o_read_word),
        .i_found_position (o_found_position),
        .i_count          (o_count),
        .i_is_full        (o_is_full),
        .i_is_empty       (o_is_empty),
        .o_failures       (failures),
        .o_pending        (pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: long hold on request, otherwise a stall pattern that changes now and then
    initial begin
        int stretch;
        int ready_mode;
        int phase;
        stretch    = 0;
        ready_mode = 0;
        phase      = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                stretch = 0;
            end else begin
                if (stretch == 0) begin
                    stretch    = $urandom_range(40, 120);
                    ready_mode = $urandom_range(0, 2);
                end
                stretch--;
                phase++;
                case (ready_mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= $urandom_range(0, 1);
                    default: i_ready <= (phase % 4 == 0);
                endcase
            end
        end
    end

    task automatic push_request(input logic [FUNC_W-1:0] f, input logic signed [VALUE_W-1:0] v,
                                input logic [INDEX_W-1:0] x);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        i_valid <= 1'b1;
        i_func  <= f;
        i_value <= v;
        i_index <= x;
        do @(posedge i_clk); while (!o_ready);
        burst_left--;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        if (burst_left != 0) begin
            i_valid <= 1'b0;
            burst_left = 0;
        end
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [FUNC_W-1:0] pick_func(input traffic_mode_t m);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            return 4'($urandom_range(FN_FIRST_UNUSED, FN_LAST_UNUSED));
        end
        case (m)
            MODE_FILL:  if (r < 70) return 4'($urandom_range(FN_APPEND, FN_SORTED));
            MODE_DRAIN: if (r < 70) return 4'($urandom_range(FN_DROP_LAST, FN_DROP_VALUE));
            default:    if (r < 60) return 4'($urandom_range(FN_READ, FN_FIND));
        endcase
        return 4'($urandom_range(FN_APPEND, FN_FIND));
    endfunction

    // small pool so that finds and drops by value hit often
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return -32'sd1;
            3:       return 32'sd0;
            4, 5, 6: return $signed(VALUE_W'($urandom_range(0, 6))) - 32'sd3;
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        if ($urandom_range(0, 1)) begin
            return 4'($urandom_range(0, 3));
        end
        return 4'($urandom_range(0, 15));
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every drop, read and find, and an unused code, on an empty list
        push_request(FN_DROP_LAST, 32'sd0, 4'd0);
        push_request(FN_DROP_FIRST, 32'sd0, 4'd0);
        push_request(FN_DROP_INDEX, 32'sd0, 4'd0);
        push_request(FN_DROP_VALUE, 32'sd0, 4'd0);
        push_request(FN_READ, 32'sd0, 4'd15);
        push_request(FN_FIND, 32'sd0, 4'd0);
        push_request(FN_FIRST_UNUSED, 32'sd0, 4'd0);
        // extremes, sorted placement incl. a tie with the last entry
        push_request(FN_APPEND, 32'sh7fffffff, 4'd0);
        push_request(FN_PREPEND, 32'sh80000000, 4'd0);
        push_request(FN_SORTED, 32'sd0, 4'd0);
        push_request(FN_SORTED, -32'sd1, 4'd0);
        push_request(FN_SORTED, 32'sh7fffffff, 4'd0);
        push_request(FN_READ, 32'sd0, 4'd0);
        push_request(FN_READ, 32'sd0, 4'd4);
        push_request(FN_READ, 32'sd0, 4'd15);
        push_request(FN_FIND, -32'sd1, 4'd0);
        push_request(FN_FIND, 32'sh7fffffff, 4'd0);
        push_request(FN_FIND, 32'sd1234, 4'd0);
        push_request(FN_DROP_INDEX, 32'sd0, 4'd5);
        push_request(FN_DROP_INDEX, 32'sd0, 4'd2);
        push_request(FN_DROP_VALUE, 32'sh7fffffff, 4'd0);
        push_request(FN_DROP_VALUE, 32'sd77, 4'd0);
        push_request(FN_DROP_FIRST, 32'sd0, 4'd0);
        push_request(FN_DROP_LAST, 32'sd0, 4'd0);
        push_request(FN_LAST_UNUSED, 32'sh5a5a5a5a, 4'd9);

        mode = MODE_FILL;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 40 == 0) begin
                mode = traffic_mode_t'($urandom_range(MODE_FILL, MODE_PROBE));
            end
            if (n == 200) begin
                long_hold_req = 1'b1;
            end
            if (n == 420) begin
                wait_drained();
            end
            push_request(pick_func(mode), pick_value(), pick_index());
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
